@@ hdl/prce_pkg.sv @@
`default_nettype none
package prce_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int COORD_BITS_DEF   = 32;
  localparam int COUNT_BITS       = 7;

  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_RAY    = 2'd1;
  localparam logic [1:0] CMD_SEG    = 2'd2;

  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_OUTSIDE  = 3'd1;
  localparam logic [2:0] ST_BOUNDARY = 3'd2;
  localparam logic [2:0] ST_STORED   = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef struct packed {
    logic capture;
    logic append;
    logic walk_init;
    logic mark_out;
    logic rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic ray_out;
    logic poly_empty;
    logic walk_last;
    logic pipe_busy;
  } ctrl_sts_t;

endpackage
`default_nettype wire

@@ hdl/polygon_ray_crossing_engine_top.sv @@
`default_nettype none
// Polygon ray-crossing engine. Vertices are appended one per beat (command 0,
// restart empties the store first); ray queries (command 1) count crossings
// of a rightward ray and segment queries (command 2) test for a strict edge
// crossing of an axis-aligned segment. One item is processed at a time. A
// query walks the vertex memory one read per cycle over n+3 reads (n stored
// vertices), followed by a 4-stage edge pipeline with the three multipliers;
// an empty polygon, or a ray query point outside the bounding box, skips the
// walk. The result sits in an output register, so the next item is taken
// while it waits.
module polygon_ray_crossing_engine_top import prce_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [1:0]                   command,
  input  wire logic                         restart,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic                         horizontal,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [2:0]                        status,
  output logic [COUNT_BITS-1:0]             crossing_count,
  output logic                              crosses
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  prce_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .command   (command),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  prce_dp #(
    .MAX_VERTICES (MAX_VERTICES),
    .COORD_BITS   (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .command        (command),
    .restart        (restart),
    .ax             (ax),
    .ay             (ay),
    .bx             (bx),
    .by             (by),
    .horizontal     (horizontal),
    .status         (status),
    .crossing_count (crossing_count),
    .crosses        (crosses)
  );

endmodule
`default_nettype wire

@@ hdl/prce_dp.sv @@
`default_nettype none
module prce_dp import prce_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int COORD_BITS   = COORD_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire ctrl_cmd_t                    cmd,
  output ctrl_sts_t                         sts,
  input  wire logic [1:0]                   command,
  input  wire logic                         restart,
  input  wire logic signed [COORD_BITS-1:0] ax,
  input  wire logic signed [COORD_BITS-1:0] ay,
  input  wire logic signed [COORD_BITS-1:0] bx,
  input  wire logic signed [COORD_BITS-1:0] by,
  input  wire logic                         horizontal,
  output logic [2:0]                        status,
  output logic [COUNT_BITS-1:0]             crossing_count,
  output logic                              crosses
);

  localparam int CW   = COORD_BITS;
  localparam int AW   = $clog2(MAX_VERTICES);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int RW   = $clog2(MAX_VERTICES + 4);
  localparam int PW   = 2 * CW + 2;

  logic signed [CW-1:0] mem_x [MAX_VERTICES];
  logic signed [CW-1:0] mem_y [MAX_VERTICES];

  logic [1:0]           q_cmd;
  logic                 q_restart;
  logic                 q_horiz;
  logic signed [CW-1:0] q_ax, q_ay, q_bx, q_by;

  logic [CNTW-1:0]      vcount;
  logic signed [CW-1:0] box_x_min, box_x_max, box_y_min, box_y_max;
  logic [2:0]           app_status;

  logic [AW-1:0]        addr;
  logic [RW-1:0]        rd_left;
  logic                 rv;
  logic signed [CW-1:0] rdx, rdy;
  logic signed [CW-1:0] wx [4];
  logic signed [CW-1:0] wy [4];
  logic [1:0]           fill;
  logic                 wv;

  logic                 s1_v, s1_skip, s1_gen, s1_bnd, s1_inc, s1_hit;
  logic signed [CW:0]   s1_d, s1_e1, s1_e2, s1_f, s1_g;
  logic                 s2_v, s2_skip, s2_gen, s2_bnd, s2_inc, s2_hit, s2_dneg;
  logic signed [PW-1:0] s2_p1, s2_p2, s2_q;

  logic                  outside, bnd_acc, cross_acc;
  logic [COUNT_BITS-1:0] cnt_acc;

  logic [CNTW-1:0]      eff;
  logic                 is_ray, swap;
  logic signed [CW-1:0] lo, hi, other, pu1, pu2, pv;
  logic signed [CW-1:0] u0, v0, u1, v1, yip, yjp;
  logic signed [CW-1:0] minu, maxu, minv, maxv;
  logic                 e_skip, e_gen, e_bnd, e_inc, e_hit, vert, horz;
  logic signed [PW:0]   sum1, sum2;
  logic                 pos1, neg2, zero1;
  logic [AW-1:0]        last_addr;

  assign eff       = q_restart ? '0 : vcount;
  assign last_addr = AW'(vcount - CNTW'(1));
  assign is_ray    = (q_cmd == CMD_RAY);
  assign swap      = !is_ray && !q_horiz;

  always_comb begin
    if (q_horiz) begin
      lo    = (q_ax < q_bx) ? q_ax : q_bx;
      hi    = (q_ax < q_bx) ? q_bx : q_ax;
      other = q_ay;
    end else begin
      lo    = (q_ay < q_by) ? q_ay : q_by;
      hi    = (q_ay < q_by) ? q_by : q_ay;
      other = q_ax;
    end
    pu1 = is_ray ? q_ax : lo;
    pu2 = hi;
    pv  = is_ray ? q_ay : other;
    u0  = swap ? wy[1] : wx[1];
    v0  = swap ? wx[1] : wy[1];
    u1  = swap ? wy[2] : wx[2];
    v1  = swap ? wx[2] : wy[2];
    yip = wy[0];
    yjp = wy[3];
    minu = (u0 < u1) ? u0 : u1;
    maxu = (u0 < u1) ? u1 : u0;
    minv = (v0 < v1) ? v0 : v1;
    maxv = (v0 < v1) ? v1 : v0;
    vert = (u0 == u1);
    horz = (v0 == v1);
    e_gen = 1'b0;
    e_bnd = 1'b0;
    e_inc = 1'b0;
    e_hit = 1'b0;
    if (is_ray) begin
      e_skip = (maxu < pu1) || (pv < minv) || (maxv < pv);
      if (vert) begin
        e_bnd = (pu1 == u0);
        e_inc = (minv < pv && pv < maxv) ||
                (pv == v1 && ((yjp > v1 && v1 > v0) || (yjp < v1 && v1 < v0)));
      end else if (horz) begin
        e_bnd = (minu <= pu1) && (pu1 < maxu);
        e_inc = (pv == v1) && ((yjp > v1) != (yip > v0));
      end else begin
        e_gen = 1'b1;
        e_inc = (pv != v0 && pv != v1) || (pv == v1 && ((yjp > v1) == (v1 > v0)));
      end
    end else begin
      e_skip = (pu2 <= minu) || (maxu <= pu1) || (pv <= minv) || (maxv <= pv);
      e_gen  = !vert;
      e_hit  = (pu1 < u0) && (u0 < pu2);
    end
  end

  always_comb begin
    sum1  = {s2_p1[PW-1], s2_p1} + {s2_q[PW-1], s2_q};
    sum2  = {s2_p2[PW-1], s2_p2} + {s2_q[PW-1], s2_q};
    zero1 = (sum1 == '0);
    pos1  = !zero1 && (sum1[PW] == s2_dneg);
    neg2  = (sum2 != '0) && (sum2[PW] != s2_dneg);
  end

  always_comb begin
    sts.ray_out    = (vcount == '0) || (q_ax > box_x_max) || (q_ax < box_x_min) ||
                     (q_ay > box_y_max) || (q_ay < box_y_min);
    sts.poly_empty = (vcount == '0);
    sts.walk_last  = (rd_left == RW'(1));
    sts.pipe_busy  = rv || wv || s1_v || s2_v;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_cmd     <= command;
      q_restart <= restart;
      q_horiz   <= horizontal;
      q_ax      <= ax;
      q_ay      <= ay;
      q_bx      <= bx;
      q_by      <= by;
    end
    if (cmd.append && eff != CNTW'(MAX_VERTICES)) begin
      mem_x[eff[AW-1:0]] <= q_ax;
      mem_y[eff[AW-1:0]] <= q_ay;
    end
    if (cmd.rd) begin
      rdx <= mem_x[addr];
      rdy <= mem_y[addr];
    end
    if (rv) begin
      wx[0] <= wx[1]; wx[1] <= wx[2]; wx[2] <= wx[3]; wx[3] <= rdx;
      wy[0] <= wy[1]; wy[1] <= wy[2]; wy[2] <= wy[3]; wy[3] <= rdy;
    end
    s1_skip <= e_skip;
    s1_gen  <= e_gen;
    s1_bnd  <= e_bnd;
    s1_inc  <= e_inc;
    s1_hit  <= e_hit;
    s1_d    <= (CW+1)'(v1) - (CW+1)'(v0);
    s1_e1   <= (CW+1)'(u0) - (CW+1)'(pu1);
    s1_e2   <= (CW+1)'(u0) - (CW+1)'(pu2);
    s1_f    <= (CW+1)'(pv) - (CW+1)'(v0);
    s1_g    <= (CW+1)'(u1) - (CW+1)'(u0);
    s2_skip <= s1_skip;
    s2_gen  <= s1_gen;
    s2_bnd  <= s1_bnd;
    s2_inc  <= s1_inc;
    s2_hit  <= s1_hit;
    s2_dneg <= s1_d[CW];
    s2_p1   <= s1_e1 * s1_d;
    s2_p2   <= s1_e2 * s1_d;
    s2_q    <= s1_f * s1_g;
    if (cmd.out_load) begin
      crossing_count <= '0;
      crosses        <= 1'b0;
      unique case (q_cmd)
        CMD_APPEND: status <= app_status;
        CMD_RAY: begin
          if (outside) begin
            status <= ST_OUTSIDE;
          end else if (bnd_acc) begin
            status <= ST_BOUNDARY;
          end else begin
            status         <= ST_VALID;
            crossing_count <= cnt_acc;
          end
        end
        CMD_SEG: begin
          status  <= ST_VALID;
          crosses <= cross_acc;
        end
        default: status <= ST_VALID;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vcount     <= '0;
      box_x_min  <= '0;
      box_x_max  <= '0;
      box_y_min  <= '0;
      box_y_max  <= '0;
      app_status <= ST_STORED;
      addr       <= '0;
      rd_left    <= '0;
      rv         <= 1'b0;
      fill       <= '0;
      wv         <= 1'b0;
      s1_v       <= 1'b0;
      s2_v       <= 1'b0;
      outside    <= 1'b0;
      bnd_acc    <= 1'b0;
      cross_acc  <= 1'b0;
      cnt_acc    <= '0;
    end else begin
      if (cmd.append) begin
        if (eff == CNTW'(MAX_VERTICES)) begin
          app_status <= ST_FULL;
        end else begin
          app_status <= ST_STORED;
          vcount     <= eff + CNTW'(1);
          if (eff == '0) begin
            box_x_min <= q_ax;
            box_x_max <= q_ax;
            box_y_min <= q_ay;
            box_y_max <= q_ay;
          end else begin
            if (q_ax < box_x_min) box_x_min <= q_ax;
            if (q_ax > box_x_max) box_x_max <= q_ax;
            if (q_ay < box_y_min) box_y_min <= q_ay;
            if (q_ay > box_y_max) box_y_max <= q_ay;
          end
        end
      end
      rv   <= cmd.rd;
      wv   <= rv && (fill == 2'd3);
      s1_v <= wv;
      s2_v <= s1_v;
      if (rv && fill != 2'd3) fill <= fill + 2'd1;
      if (cmd.walk_init) begin
        addr      <= last_addr;
        rd_left   <= RW'(vcount) + RW'(3);
        fill      <= '0;
        outside   <= cmd.mark_out;
        bnd_acc   <= 1'b0;
        cross_acc <= 1'b0;
        cnt_acc   <= '0;
      end else begin
        if (cmd.rd) begin
          addr    <= (addr == last_addr) ? '0 : addr + AW'(1);
          rd_left <= rd_left - RW'(1);
        end
        if (s2_v && !s2_skip) begin
          if (is_ray) begin
            if (s2_gen) begin
              if (zero1) begin
                bnd_acc <= 1'b1;
              end else if (pos1 && s2_inc && cnt_acc != '1) begin
                cnt_acc <= cnt_acc + COUNT_BITS'(1);
              end
            end else if (s2_bnd) begin
              bnd_acc <= 1'b1;
            end else if (s2_inc && cnt_acc != '1) begin
              cnt_acc <= cnt_acc + COUNT_BITS'(1);
            end
          end else if (s2_gen ? (pos1 && neg2) : s2_hit) begin
            cross_acc <= 1'b1;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/prce_ctrl.sv @@
`default_nettype none
module prce_ctrl import prce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  output logic            out_valid,
  input  wire logic       out_stall,
  output ctrl_cmd_t       cmd,
  input  wire ctrl_sts_t  sts
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DISP  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0] state, state_next;
  logic [1:0] q_cmd;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (accept && (command == CMD_APPEND || command == CMD_RAY ||
                       command == CMD_SEG)) begin
          cmd.capture = 1'b1;
          state_next  = S_DISP;
        end
      end
      S_DISP: begin
        unique case (q_cmd)
          CMD_APPEND: begin
            cmd.append = 1'b1;
            state_next = S_FIN;
          end
          CMD_RAY: begin
            cmd.walk_init = 1'b1;
            cmd.mark_out  = sts.ray_out;
            state_next    = sts.ray_out ? S_FIN : S_WALK;
          end
          CMD_SEG: begin
            cmd.walk_init = 1'b1;
            state_next    = sts.poly_empty ? S_FIN : S_WALK;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_WALK: begin
        cmd.rd = 1'b1;
        if (sts.walk_last) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (!sts.pipe_busy) state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) q_cmd <= command;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= cmd.out_load || (out_valid && out_stall);
    end
  end

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |=> out_valid)
    else $error("loaded beat not presented");

  a_drain_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_DRAIN && !sts.pipe_busy) |=> (state == S_FIN))
    else $error("drain did not finish");

  a_rise_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FIN))
    else $error("result beat outside finish");

  a_walk_reads: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> sts.pipe_busy)
    else $error("walk read lost");

endmodule
`default_nettype wire
